// ===== sv/fbpst_pkg.sv =====
`timescale 1ns / 1ps

package fbpst_pkg;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 64;
  localparam int CFG_W  = 9;
  localparam logic [CFG_W-1:0] PPB_RESET = 9'd256;
  localparam logic [31:0] ERASE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_WRITE_NEXT = 3'd0,
    ACT_WRITE_AT   = 3'd1,
    ACT_MARK       = 3'd2,
    ACT_READ       = 3'd3,
    ACT_ERASE      = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NOT_FREE = 2'd2,
    STS_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PS_FREE    = 2'd0,
    PS_VALID   = 2'd1,
    PS_INVALID = 2'd2
  } pstate_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SKIP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic latch;
    logic rd;
    logic exec;
    logic skip;
    logic fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip_need;
    logic skip_more;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/flash_block_page_state_tracker_top.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata: action[2:0] page[10:3] mark_invalid[11]
// m_*      out  tvalid/tready    tdata: status, pg_state, written_page, counts, flags
// cfg_*    in   cfg_we_i         cfg_wdata_i: pages_per_block
//
// Each transaction steps through accept, word read, execute and result; a
// write-at that skips across bitmap words adds a skip step per further word,
// as the bitmap memory has a single write port.
// Reset clears pointer, counters and per-word valid bits; bitmap words read as
// all-valid until written. A result waits in the output register while the
// next transaction is accepted; a stalled result holds the sequencer in its
// final step.

module flash_block_page_state_tracker_top #(
  parameter int MAX_PAGES = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbpst_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // action[2:0], page[10:3], mark_invalid[11], zero[15:12]
  input  logic [fbpst_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], pg_state[3:2], written_page[11:4], valid_count[20:12],
  // free_count[29:21], erase_total[61:30], is_empty_flag[62], is_full_flag[63]
  output logic [fbpst_pkg::OUT_W-1:0] m_tdata
);

  fbpst_pkg::ctl_cmd_t cmd;
  fbpst_pkg::dp_sts_t  sts;

  fbpst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbpst_dp #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_action_i       (s_tdata[2:0]),
    .in_page_i         (s_tdata[10:3]),
    .in_mark_invalid_i (s_tdata[11]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (m_tready),
    .out_valid_o       (m_tvalid),
    .out_data_o        (m_tdata)
  );

endmodule

// ===== sv/fbpst_ctrl.sv =====
`timescale 1ns / 1ps

module fbpst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbpst_pkg::dp_sts_t  sts_i,
  output fbpst_pkg::ctl_cmd_t cmd_o
);

  fbpst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      fbpst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = fbpst_pkg::ST_LOOK;
        end
      end
      fbpst_pkg::ST_LOOK: begin
        cmd_o.rd = 1'b1;
        state_d  = fbpst_pkg::ST_EXEC;
      end
      fbpst_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.skip_need ? fbpst_pkg::ST_SKIP : fbpst_pkg::ST_FIN;
      end
      fbpst_pkg::ST_SKIP: begin
        cmd_o.skip = 1'b1;
        if (!sts_i.skip_more) begin
          state_d = fbpst_pkg::ST_FIN;
        end
      end
      fbpst_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = fbpst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fbpst_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == fbpst_pkg::ST_LOOK)
    else $error("accepted transaction did not start a lookup");

  a_exec_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fbpst_pkg::ST_LOOK |=> state_q == fbpst_pkg::ST_EXEC)
    else $error("lookup not followed by execute");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.latch, cmd_o.rd, cmd_o.exec, cmd_o.skip, cmd_o.fin}))
    else $error("more than one datapath command at once");

endmodule

// ===== sv/fbpst_dp.sv =====
`timescale 1ns / 1ps

module fbpst_dp #(
  parameter int MAX_PAGES = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbpst_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [2:0]                    in_action_i,
  input  logic [7:0]                    in_page_i,
  input  logic                          in_mark_invalid_i,
  input  fbpst_pkg::ctl_cmd_t           cmd_i,
  output fbpst_pkg::dp_sts_t            sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [fbpst_pkg::OUT_W-1:0]   out_data_o
);

  localparam int LOG_W     = $clog2(WORD_BITS);
  localparam int WB        = 1 << LOG_W;
  localparam int NUM_WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int NW_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SPAN_W    = $clog2(NUM_WORDS * WB + 1);
  localparam int EW        = (SPAN_W > fbpst_pkg::CFG_W) ? SPAN_W : fbpst_pkg::CFG_W;
  localparam logic [EW-1:0] MAXP   = EW'(MAX_PAGES);
  localparam logic [EW-1:0] NWORDS = EW'(NUM_WORDS);

  logic [2:0]                  act_q;
  logic [EW-1:0]               page_q;
  logic                        inv_q;
  logic [EW-1:0]               wp_q, wp_d;
  logic [EW-1:0]               vc_q, vc_d;
  logic [31:0]                 erase_q, erase_d;
  logic [fbpst_pkg::CFG_W-1:0] ppb_q;
  logic [WB-1:0]               mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]        wvld_q;
  logic [WB-1:0]               rdata_q;
  logic                        rvld_q;
  logic [NW_W-1:0]             widx_q;
  logic [EW-1:0]               cur_q;
  fbpst_pkg::status_e          status_q, status_d;
  fbpst_pkg::pstate_e          pstate_q, pstate_d;
  logic [7:0]                  wpage_q, wpage_d;
  logic                        out_valid_q;
  logic [fbpst_pkg::OUT_W-1:0] out_data_q;

  logic [EW-1:0]   eff;
  logic            full;
  logic [EW-1:0]   rd_word;
  logic            rd_ok;
  logic [WB-1:0]   old;
  logic            old_bit;
  logic            mem_we;
  logic [NW_W-1:0] mem_waddr;
  logic [WB-1:0]   mem_wdata;
  logic            erase_clr;
  logic [EW-1:0]   first_next;
  logic [EW-1:0]   cur_next;
  logic [EW-1:0]   free_cnt;

  function automatic logic [WB-1:0] range_mask(logic [EW-1:0] word, logic [EW-1:0] lo,
                                               logic [EW-1:0] hi);
    logic [WB-1:0] m;
    logic [EW-1:0] base;
    logic [EW-1:0] pos;
    base = word << LOG_W;
    for (int b = 0; b < WB; b++) begin
      pos  = base + EW'(b);
      m[b] = (pos >= lo) && (pos < hi);
    end
    return m;
  endfunction

  assign eff        = (EW'(ppb_q) > MAXP) ? MAXP : EW'(ppb_q);
  assign full       = wp_q >= eff;
  assign rd_word    = ((act_q == fbpst_pkg::ACT_WRITE_AT) ? wp_q : page_q) >> LOG_W;
  assign rd_ok      = rd_word < NWORDS;
  assign old        = rvld_q ? rdata_q : '0;
  assign old_bit    = old[page_q[LOG_W-1:0]];
  assign first_next = EW'(widx_q) + EW'(1);
  assign cur_next   = cur_q + EW'(1);
  assign free_cnt   = (eff > wp_q) ? (eff - wp_q) : '0;

  always_comb begin
    wp_d      = wp_q;
    vc_d      = vc_q;
    erase_d   = erase_q;
    status_d  = status_q;
    pstate_d  = pstate_q;
    wpage_d   = wpage_q;
    mem_we    = 1'b0;
    mem_waddr = widx_q;
    mem_wdata = old;
    erase_clr = 1'b0;
    sts_o     = '0;
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.skip_more = (cur_next << LOG_W) < page_q;
    if (cmd_i.exec) begin
      status_d = fbpst_pkg::STS_OK;
      pstate_d = fbpst_pkg::PS_FREE;
      wpage_d  = '0;
      case (act_q)
        fbpst_pkg::ACT_WRITE_NEXT: begin
          if (full) begin
            status_d = fbpst_pkg::STS_FULL;
          end else begin
            wpage_d = wp_q[7:0];
            wp_d    = wp_q + EW'(1);
            vc_d    = vc_q + EW'(1);
          end
        end
        fbpst_pkg::ACT_WRITE_AT: begin
          if (full) begin
            status_d = fbpst_pkg::STS_FULL;
          end else if (page_q >= eff) begin
            status_d = fbpst_pkg::STS_RANGE;
          end else if (page_q < wp_q) begin
            status_d = fbpst_pkg::STS_NOT_FREE;
          end else begin
            mem_we          = 1'b1;
            mem_wdata       = old | range_mask(EW'(widx_q), wp_q, page_q);
            wp_d            = page_q + EW'(1);
            vc_d            = vc_q + EW'(1);
            wpage_d         = page_q[7:0];
            sts_o.skip_need = (first_next << LOG_W) < page_q;
          end
        end
        fbpst_pkg::ACT_MARK: begin
          if (page_q >= eff) begin
            status_d = fbpst_pkg::STS_RANGE;
          end else if (page_q >= wp_q) begin
            status_d = fbpst_pkg::STS_NOT_FREE;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = old;
            mem_wdata[page_q[LOG_W-1:0]] = inv_q;
            if (old_bit && !inv_q) begin
              vc_d = vc_q + EW'(1);
            end else if (!old_bit && inv_q && (vc_q != '0)) begin
              vc_d = vc_q - EW'(1);
            end
          end
        end
        fbpst_pkg::ACT_READ: begin
          if (page_q >= eff) begin
            status_d = fbpst_pkg::STS_RANGE;
          end else if (page_q < wp_q) begin
            pstate_d = old_bit ? fbpst_pkg::PS_INVALID : fbpst_pkg::PS_VALID;
          end
        end
        fbpst_pkg::ACT_ERASE: begin
          erase_clr = 1'b1;
          wp_d      = '0;
          vc_d      = '0;
          if (erase_q != fbpst_pkg::ERASE_MAX) begin
            erase_d = erase_q + 32'd1;
          end
        end
        default: begin
          status_d = fbpst_pkg::STS_RANGE;
        end
      endcase
    end
    if (cmd_i.skip) begin
      mem_we    = 1'b1;
      mem_waddr = cur_q[NW_W-1:0];
      mem_wdata = range_mask(cur_q, '0, page_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      vc_q        <= '0;
      erase_q     <= '0;
      ppb_q       <= fbpst_pkg::PPB_RESET;
      wvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      vc_q    <= vc_d;
      erase_q <= erase_d;
      if (cfg_we_i) begin
        ppb_q <= cfg_wdata_i;
      end
      if (erase_clr) begin
        wvld_q <= '0;
      end else if (mem_we) begin
        wvld_q[mem_waddr] <= 1'b1;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd && rd_ok) begin
      rdata_q <= mem[rd_word[NW_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= in_action_i;
      page_q <= EW'(in_page_i);
      inv_q  <= in_mark_invalid_i;
    end
    if (cmd_i.rd) begin
      rvld_q <= rd_ok && wvld_q[rd_word[NW_W-1:0]];
      widx_q <= rd_word[NW_W-1:0];
    end
    if (cmd_i.exec) begin
      cur_q <= first_next;
    end else if (cmd_i.skip) begin
      cur_q <= cur_next;
    end
    status_q <= status_d;
    pstate_q <= pstate_d;
    wpage_q  <= wpage_d;
    if (cmd_i.fin) begin
      out_data_q <= {full, (wp_q == '0), erase_q, free_cnt[8:0], vc_q[8:0], wpage_q,
                     pstate_q, status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_vc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= wp_q)
    else $error("valid count above write pointer");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= MAXP)
    else $error("write pointer beyond block");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> out_valid_q)
    else $error("result not presented after finish");

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule
